### design/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_END  = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  // one decoded input byte: up to four result bytes, emitted 0..last_idx
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    status_e         status;
    logic            key;
  } job_t;

endpackage

`default_nettype wire

### design/jsu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [7:0]   in_byte_i,
  input  wire logic         start_req_i,
  input  wire logic         is_key_i,
  output logic              push_o,
  output jsu_pkg::job_t     job_o
);
  import jsu_pkg::*;

  typedef enum logic [3:0] {
    PH_PLAIN   = 4'd0,
    PH_ESC     = 4'd1,
    PH_HEX1    = 4'd2,
    PH_HEX2    = 4'd3,
    PH_HEX3    = 4'd4,
    PH_HEX4    = 4'd5,
    PH_NEED_BS = 4'd6,
    PH_NEED_U  = 4'd7,
    PH_LOW1    = 4'd8,
    PH_LOW2    = 4'd9,
    PH_LOW3    = 4'd10,
    PH_LOW4    = 4'd11,
    PH_DONE    = 4'd12,
    PH_ERR     = 4'd13
  } phase_e;

  phase_e      phase_q, phase_d, phase_cur;
  logic [15:0] acc_q, acc_d, acc_cur, acc_new;
  logic [9:0]  hs_q, hs_d, hs_cur;
  logic        key_q, key_d, key_cur;
  logic        digit_ok;
  logic [3:0]  digit;
  logic [4:0]  plane;
  logic        has_res;
  job_t        job;

  function automatic job_t utf8_enc(input logic [20:0] cp);
    job_t j;
    j = '0;
    if (cp <= 21'h7F) begin
      j.bytes[0] = cp[7:0];
      j.last_idx = 2'd0;
    end else if (cp <= 21'h7FF) begin
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
      j.last_idx = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
      j.last_idx = 2'd2;
    end else begin
      // surrogate pairs never exceed 0x10FFFF
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
      j.last_idx = 2'd3;
    end
    return j;
  endfunction

  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      digit = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      digit = 4'(in_byte_i - 8'h37);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      digit = 4'(in_byte_i - 8'h57);
    end else begin
      digit_ok = 1'b0;
    end
  end

  // start flag clears state ahead of the byte it comes with
  assign phase_cur = start_req_i ? PH_PLAIN : phase_q;
  assign acc_cur   = start_req_i ? 16'd0 : acc_q;
  assign hs_cur    = start_req_i ? 10'd0 : hs_q;
  assign key_cur   = start_req_i ? is_key_i : key_q;
  assign acc_new   = {acc_cur[11:0], digit};
  // pair offset of 0x10000 lands on the plane bits only
  assign plane     = {1'b0, hs_cur[9:6]} + 5'd1;

  always_comb begin
    phase_d    = phase_cur;
    acc_d      = acc_cur;
    hs_d       = hs_cur;
    key_d      = key_cur;
    has_res    = 1'b0;
    job        = '0;
    job.status = ST_DATA;
    case (phase_cur)
      PH_PLAIN: begin
        if (in_byte_i == 8'h22) begin
          phase_d    = PH_DONE;
          has_res    = 1'b1;
          job.status = ST_END;
        end else if (in_byte_i == 8'h5C) begin
          phase_d = PH_ESC;
        end else if (in_byte_i[7:5] == 3'b000) begin
          phase_d    = PH_ERR;
          has_res    = 1'b1;
          job.status = ST_ERR;
        end else begin
          has_res      = 1'b1;
          job.bytes[0] = in_byte_i;
        end
      end
      PH_ESC: begin
        phase_d = PH_PLAIN;
        has_res = 1'b1;
        case (in_byte_i)
          8'h22, 8'h2F, 8'h5C: job.bytes[0] = in_byte_i;
          8'h62:   job.bytes[0] = 8'h08;
          8'h66:   job.bytes[0] = 8'h0C;
          8'h6E:   job.bytes[0] = 8'h0A;
          8'h72:   job.bytes[0] = 8'h0D;
          8'h74:   job.bytes[0] = 8'h09;
          8'h75: begin
            phase_d = PH_HEX1;
            acc_d   = 16'd0;
            has_res = 1'b0;
          end
          default: begin
            phase_d    = PH_ERR;
            job.status = ST_ERR;
          end
        endcase
      end
      PH_HEX1, PH_HEX2, PH_HEX3, PH_LOW1, PH_LOW2, PH_LOW3: begin
        if (!digit_ok) begin
          phase_d    = PH_ERR;
          has_res    = 1'b1;
          job.status = ST_ERR;
        end else begin
          acc_d   = acc_new;
          phase_d = phase_e'(phase_cur + 4'd1);
        end
      end
      PH_HEX4: begin
        if (!digit_ok) begin
          phase_d    = PH_ERR;
          has_res    = 1'b1;
          job.status = ST_ERR;
        end else begin
          acc_d = acc_new;
          if (acc_new[15:10] == 6'b110110) begin
            hs_d    = acc_new[9:0];
            phase_d = PH_NEED_BS;
          end else begin
            phase_d    = PH_PLAIN;
            has_res    = 1'b1;
            job        = utf8_enc({5'd0, acc_new});
            job.status = ST_DATA;
          end
        end
      end
      PH_NEED_BS: begin
        if (in_byte_i == 8'h5C) begin
          phase_d = PH_NEED_U;
        end else begin
          phase_d    = PH_ERR;
          has_res    = 1'b1;
          job.status = ST_ERR;
        end
      end
      PH_NEED_U: begin
        if (in_byte_i inside {8'h55, 8'h75}) begin
          phase_d = PH_LOW1;
          acc_d   = 16'd0;
        end else begin
          phase_d    = PH_ERR;
          has_res    = 1'b1;
          job.status = ST_ERR;
        end
      end
      PH_LOW4: begin
        has_res = 1'b1;
        if (!digit_ok || acc_new[15:10] != 6'b110111) begin
          phase_d    = PH_ERR;
          job.status = ST_ERR;
          if (digit_ok) begin
            acc_d = acc_new;
          end
        end else begin
          acc_d      = acc_new;
          phase_d    = PH_PLAIN;
          job        = utf8_enc({plane[4:0], hs_cur[5:0], acc_new[9:0]});
          job.status = ST_DATA;
        end
      end
      default: begin
        // string ended or sticky error: byte ignored
      end
    endcase
    job.key = key_cur;
  end

  assign push_o = accept_i && has_res;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      acc_q   <= 16'd0;
      hs_q    <= 10'd0;
      key_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      hs_q    <= hs_d;
      key_q   <= key_d;
    end
  end

endmodule

`default_nettype wire

### design/jsu_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  jsu_pkg::job_t      wdata_i,
  input  wire logic          pop_i,
  output jsu_pkg::job_t      rdata_o,
  output logic               empty_o,
  output logic               full_o
);
  import jsu_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth))
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("transfer pushed into full queue");
`endif

endmodule

`default_nettype wire

### design/jsu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  jsu_pkg::job_t     head_i,
  input  wire logic         empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic [1:0]        status_o,
  output logic              last_o,
  output logic              key_flag_o
);
  import jsu_pkg::*;

  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  logic [7:0] byte_q;
  logic [1:0] status_q;
  logic       last_q, key_q;
  logic       load, take, at_last;

  assign load    = !valid_q || out_ready_i;
  assign take    = load && !empty_i;
  assign at_last = (idx_q == head_i.last_idx);
  assign pop_o   = take && at_last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = !empty_i;
    end
    if (take) begin
      idx_d = at_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q   <= head_i.bytes[idx_q];
      status_q <= head_i.status;
      last_q   <= at_last;
      key_q    <= head_i.key;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign status_o    = status_q;
  assign last_o      = last_q;
  assign key_flag_o  = key_q;

`ifndef SYNTHESIS
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> idx_q == 2'd0)
    else $error("byte index left over with queue empty");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q <= head_i.last_idx)
    else $error("byte index past end of job");
`endif

endmodule

`default_nettype wire

### design/json_string_unescape_utf8_core.sv
// JSON string body unescaper with UTF-8 output. Feed the bytes after the
// opening quote, closing quote included, one per transfer; start_req_i on the
// first byte of a string clears state and latches is_key_i. Each byte gives
// 0 to 4 results (data bytes, an end marker or a sticky error), the final one
// flagged by last_o. An input byte is taken every cycle while the job queue
// (QueueDepth entries) has room; the output side emits one result per cycle
// while out_ready_i is high, so the results of a byte leave one after another
// and the queue soaks up such bursts. The first result of a byte is written
// into the queue at its transfer and reaches the outputs only once the output
// register has loaded it from the queue head.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       start_req_i,
  input  wire logic       is_key_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      status_o,
  output logic            last_o,
  output logic            key_flag_o
);
  import jsu_pkg::*;

  logic  full, empty, push, pop, accept;
  job_t  wjob, head;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .start_req_i (start_req_i),
    .is_key_i    (is_key_i),
    .push_o      (push),
    .job_o       (wjob)
  );

  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wjob),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (empty),
    .full_o  (full)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o),
    .key_flag_o  (key_flag_o)
  );

endmodule

`default_nettype wire
